[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hdl/bvdm_pkg.sv]
// ----------------------------------------------------------------------------
// bvdm_pkg
// Types, coefficients and arithmetic helpers for the brine property pipeline
// ----------------------------------------------------------------------------
package bvdm_pkg;

    // signed Q.28 working value
    typedef logic signed [47:0] q_t;

    localparam int unsigned FRAC_BITS = 28;

    // integer square root state
    typedef struct packed {
        logic [31:0] n;
        logic [31:0] res;
    } sq_t;

    typedef struct packed {
        logic        clip;
        logic [19:0] val;
    } spd_sat_t;

    typedef struct packed {
        logic        clip;
        logic [17:0] val;
    } rho_sat_t;

    // stage records
    typedef struct packed {
        logic [15:0]  x;
        logic [14:0]  y;
        logic [15:0]  s;
        sq_t          sq;
        q_t [4:0]     wa;
        q_t           p1;
        q_t           q1;
        q_t           q2;
        q_t           vq;
        q_t           m1820;
        q_t           dt;
        q_t           du;
        q_t           dv;
        q_t           a1;
        q_t           a2c;
        q_t           a3;
        q_t           a4;
        q_t           a5c;
    } st1_t;

    typedef struct packed {
        logic [15:0]  x;
        logic [14:0]  y;
        logic [15:0]  s;
        sq_t          sq;
        q_t [4:0]     wb;
        q_t           p2;
        q_t           qs;
        q_t           vbq;
        q_t           m1820;
        q_t           dt2;
        q_t           du2;
        q_t           dv2;
        q_t           a1;
        q_t           b1;
        q_t           bsum;
    } st2_t;

    typedef struct packed {
        logic [15:0]  x;
        logic [14:0]  y;
        logic [15:0]  s;
        sq_t          sq;
        q_t [4:0]     rr;
        q_t           va;
        q_t           vbq;
        q_t           m1820;
        q_t           tw;
        q_t           uw;
        q_t           t2;
    } st3_t;

    typedef struct packed {
        logic [15:0]  x;
        logic [15:0]  s;
        logic [15:0]  r;
        q_t           h;
        q_t           r0;
        q_t           r1;
        q_t           r2;
        q_t           va;
        q_t           vbq;
        q_t           m1820;
        q_t           rw;
        q_t           t2;
    } st4_t;

    typedef struct packed {
        logic [15:0]  x;
        logic [15:0]  s;
        q_t           h;
        q_t           r0;
        q_t           r1;
        q_t           vin;
        q_t           rw;
        q_t           rb;
    } st5_t;

    typedef struct packed {
        logic [15:0]  x;
        logic [15:0]  s;
        q_t           h;
        q_t           r0;
        q_t           vin;
        q_t           rw;
        q_t           rb;
    } st6_t;

    typedef struct packed {
        logic [15:0]  s;
        q_t           vw;
        q_t           vin;
        q_t           rw;
        q_t           rb;
    } st7_t;

    typedef struct packed {
        q_t           vw;
        q_t           vb;
        q_t           rw;
        q_t           rb;
    } st8_t;

    // saturated outputs plus a scratch product for the bulk modulus
    typedef struct packed {
        logic [19:0]  o_vw;
        logic [19:0]  o_vb;
        logic [17:0]  o_rw;
        logic [17:0]  o_rb;
        logic         clip;
        logic [57:0]  acc;
    } res_t;

    typedef struct packed {
        logic [19:0]  o_vw;
        logic [19:0]  o_vb;
        logic [17:0]  o_rw;
        logic [17:0]  o_rb;
        logic [16:0]  bulk;
        logic         clip;
    } out_t;

    // round(mant * 10^-dec * 2^(bin + FRAC_BITS)), ties away from zero
    function automatic q_t cf(input longint mant, input int unsigned dec,
                              input int unsigned bin);
        logic [63:0] d;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        logic        neg;
        d = 64'd1;
        for (int unsigned i = 0; i < dec; i++)
        begin
            d = d * 64'd10;
        end
        neg = (mant < 0);
        mag = neg ? 64'(-mant) : 64'(mant);
        q   = '0;
        r   = '0;
        // long division, numerator bits first, then the binary scale
        for (int unsigned i = 0; i < 64 + bin + FRAC_BITS; i++)
        begin
            r   = {r[62:0], mag[63]};
            mag = {mag[62:0], 1'b0};
            q   = {q[62:0], 1'b0};
            if (r >= d)
            begin
                q = q + 64'd1;
                r = r - d;
            end
        end
        if ({r[62:0], 1'b0} >= d)
        begin
            q = q + 64'd1;
        end
        return neg ? -q_t'(q[47:0]) : q_t'(q[47:0]);
    endfunction

    // a * v / 2^16, nearest, ties away from zero
    function automatic q_t mul_x(input q_t a, input logic [15:0] v);
        logic [46:0] mag;
        logic [63:0] p;
        q_t          m;
        mag = a[47] ? 47'(-a) : a[46:0];
        p   = 64'(mag) * 64'(v) + 64'd32768;
        m   = q_t'(p[63:16]);
        return a[47] ? -m : m;
    endfunction

    // a * v / 2^15, nearest, ties away from zero
    function automatic q_t mul_y(input q_t a, input logic [14:0] v);
        logic [46:0] mag;
        logic [63:0] p;
        q_t          m;
        mag = a[47] ? 47'(-a) : a[46:0];
        p   = 64'(mag) * 64'(v) + 64'd16384;
        m   = q_t'(p[62:15]);
        return a[47] ? -m : m;
    endfunction

    // four digit steps of the bitwise square root, starting at step first
    function automatic sq_t sqrt_steps(input sq_t st, input int unsigned first);
        logic [31:0] bitv;
        logic [32:0] trial;
        sq_t         o;
        o = st;
        for (int unsigned k = 0; k < 4; k++)
        begin
            bitv  = 32'd1 << (30 - 2 * (first + k));
            trial = {1'b0, o.res} + {1'b0, bitv};
            if ({1'b0, o.n} >= trial)
            begin
                o.n   = o.n - trial[31:0];
                o.res = (o.res >> 1) + bitv;
            end
            else
            begin
                o.res = o.res >> 1;
            end
        end
        return o;
    endfunction

    localparam logic [19:0] SPEED_MAX = 20'd1048575;
    localparam logic [17:0] RHO_MAX   = 18'd196607;
    localparam logic [16:0] BULK_MAX  = 17'd131071;

    // Q.28 to 1/256 m/s, ties up, saturating
    function automatic spd_sat_t sat_speed(input q_t v);
        q_t       sum;
        spd_sat_t o;
        sum = v + q_t'(48'd524288);
        if (sum < 0)
        begin
            o = '{clip: 1'b1, val: '0};
        end
        else if (|sum[47:40])
        begin
            o = '{clip: 1'b1, val: SPEED_MAX};
        end
        else
        begin
            o = '{clip: 1'b0, val: sum[39:20]};
        end
        return o;
    endfunction

    // Q.28 to 1/65536 g/cc, ties up, saturating
    function automatic rho_sat_t sat_rho(input q_t v);
        q_t       sum;
        rho_sat_t o;
        sum = v + q_t'(48'd2048);
        if (sum < 0)
        begin
            o = '{clip: 1'b1, val: '0};
        end
        else if (sum[47:12] > 36'(RHO_MAX))
        begin
            o = '{clip: 1'b1, val: RHO_MAX};
        end
        else
        begin
            o = '{clip: 1'b0, val: sum[29:12]};
        end
        return o;
    endfunction

    // water velocity, [power of T][power of P]
    localparam q_t WV_COEF [5][4] = '{
        '{cf(140285, 2, 0),  cf(1524, 3, 7),    cf(3437, 6, 14),   cf(-1197, 8, 21)},
        '{cf(4871, 3, 8),    cf(-111, 4, 15),   cf(1739, 7, 22),   cf(-1628, 9, 29)},
        '{cf(-4783, 5, 16),  cf(2747, 7, 23),   cf(-2135, 9, 30),  cf(1237, 11, 37)},
        '{cf(1487, 7, 24),   cf(-6503, 10, 31), cf(-1455, 11, 38), cf(1327, 13, 45)},
        '{cf(-2197, 10, 32), cf(7987, 13, 39),  cf(5230, 14, 46),  cf(-4614, 16, 53)}
    };

    // brine velocity
    localparam q_t VA_C0  = cf(1170, 0, 0);
    localparam q_t VA_P1  = cf(26, 1, 7);
    localparam q_t VA_P2  = cf(-476, 4, 14);
    localparam q_t VA_T1  = cf(-96, 1, 8);
    localparam q_t VA_TP  = cf(-29, 4, 15);
    localparam q_t VA_T2  = cf(55, 3, 16);
    localparam q_t VA_T3  = cf(-85, 6, 24);
    localparam q_t VB_C0  = cf(780, 0, 0);
    localparam q_t VB_P1  = cf(-10, 0, 7);
    localparam q_t VB_P2  = cf(16, 2, 14);
    localparam q_t VB_S2  = cf(-1820, 0, 0);

    // water density
    localparam q_t RW_ONE = cf(1, 0, 0);
    localparam q_t RW_T1  = cf(-80, 6, 8);
    localparam q_t RW_T2  = cf(-33, 7, 16);
    localparam q_t RW_T3  = cf(175, 11, 24);
    localparam q_t RW_U0  = cf(489, 6, 7);
    localparam q_t RW_U1  = cf(-2, 6, 15);
    localparam q_t RW_U2  = cf(16, 9, 23);
    localparam q_t RW_U3  = cf(-13, 12, 31);
    localparam q_t RW_V0  = cf(-333, 9, 14);
    localparam q_t RW_V1  = cf(-2, 9, 22);

    // brine density
    localparam q_t RB_C0  = cf(668, 3, 0);
    localparam q_t RB_S   = cf(44, 2, 0);
    localparam q_t RB_P   = cf(3, 4, 7);
    localparam q_t RB_PS  = cf(-24, 4, 7);
    localparam q_t RB_T   = cf(8, 5, 8);
    localparam q_t RB_TT  = cf(3, 6, 16);
    localparam q_t RB_TS  = cf(-33, 4, 8);
    localparam q_t RB_TP  = cf(-13, 6, 15);
    localparam q_t RB_TPS = cf(47, 6, 15);

    // bulk modulus: divide by 1000 * 2^28 as a shift by 31 then times 1/125
    localparam logic [58:0] BULK_HALF  = 59'd134217728000;
    localparam logic [28:0] BULK_RECIP = 29'd274877907;

endpackage

[hdl/brine_velocity_density_modulus_top.sv]
// ----------------------------------------------------------------------------
// brine_velocity_density_modulus_top
// Stateless brine velocity, density and bulk modulus pipeline
// ----------------------------------------------------------------------------
// Takes temperature, pore pressure and salinity on one beat and returns water
// and brine velocity, water and brine density and the brine bulk modulus,
// with a flag when any output saturated. A new beat is taken every cycle
// while the output is not held, and each result passes through the water
// velocity chain (three multiply stages in pressure, four in temperature),
// one brine velocity stage, one saturation stage and four stages for the
// rho * v^2 / 1000 product. Stages with no valid beat collapse under a
// downstream stall, so the input stays ready until the pipeline is full.

`include "assert_macros.svh"

module brine_velocity_density_modulus_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // temp_c[15:0], press_mpa[30:16], salt_frac[46:31], zero pad[47]
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // water_speed[19:0], brine_speed[39:20], water_rho[57:40],
    // brine_dens[75:58], brine_bulk[92:76], zero pad[95:93]
    output logic [95:0]  m_axis_tdata,
    // clipped[0]
    output logic         m_axis_tuser
);

    bvdm_pkg::st1_t st1_reg, st1_next;
    bvdm_pkg::st2_t st2_reg, st2_next;
    bvdm_pkg::st3_t st3_reg, st3_next;
    bvdm_pkg::st4_t st4_reg, st4_next;
    bvdm_pkg::st5_t st5_reg, st5_next;
    bvdm_pkg::st6_t st6_reg, st6_next;
    bvdm_pkg::st7_t st7_reg, st7_next;
    bvdm_pkg::st8_t st8_reg, st8_next;
    bvdm_pkg::res_t st9_reg, st9_next;
    bvdm_pkg::res_t st10_reg, st10_next;
    bvdm_pkg::res_t st11_reg, st11_next;
    bvdm_pkg::res_t st12_reg, st12_next;
    bvdm_pkg::out_t st13_reg, st13_next;

    logic [13:1] vld_reg, vld_next;
    logic [13:1] vld_in;
    logic [13:1] en;

    bvdm_pkg::sq_t     sq_init;
    bvdm_pkg::sq_t     sq_last;
    bvdm_pkg::spd_sat_t sat_vw, sat_vb;
    bvdm_pkg::rho_sat_t sat_rw, sat_rb;
    logic [58:0]       bulk_sum;
    logic [21:0]       bulk_raw;

    // stage enables: a stage loads when empty or when its successor loads
    always_comb
    begin
        en[13] = !vld_reg[13] || m_axis_tready;
        for (int k = 12; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k + 1];
        end
    end

    assign vld_in   = {vld_reg[12:1], s_axis_tvalid};
    assign vld_next = (en & vld_in) | (~en & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: first multiply of every chain, sqrt steps 0-3
    always_comb
    begin
        st1_next.x = s_axis_tdata[15:0];
        st1_next.y = s_axis_tdata[30:16];
        st1_next.s = s_axis_tdata[46:31];
        sq_init.n   = {s_axis_tdata[46:31], 16'd0};
        sq_init.res = '0;
        st1_next.sq = bvdm_pkg::sqrt_steps(sq_init, 0);
        for (int i = 0; i < 5; i++)
        begin
            st1_next.wa[i] = bvdm_pkg::WV_COEF[i][2]
                           + bvdm_pkg::mul_y(bvdm_pkg::WV_COEF[i][3], st1_next.y);
        end
        st1_next.p1    = bvdm_pkg::VA_P1 + bvdm_pkg::mul_y(bvdm_pkg::VA_P2, st1_next.y);
        st1_next.q1    = bvdm_pkg::mul_y(bvdm_pkg::VA_TP, st1_next.y);
        st1_next.q2    = bvdm_pkg::VA_T2 + bvdm_pkg::mul_x(bvdm_pkg::VA_T3, st1_next.x);
        st1_next.vq    = bvdm_pkg::VB_P1 + bvdm_pkg::mul_y(bvdm_pkg::VB_P2, st1_next.y);
        st1_next.m1820 = bvdm_pkg::mul_x(bvdm_pkg::VB_S2, st1_next.s);
        st1_next.dt    = bvdm_pkg::RW_T2 + bvdm_pkg::mul_x(bvdm_pkg::RW_T3, st1_next.x);
        st1_next.du    = bvdm_pkg::RW_U2 + bvdm_pkg::mul_x(bvdm_pkg::RW_U3, st1_next.x);
        st1_next.dv    = bvdm_pkg::RW_V0 + bvdm_pkg::mul_x(bvdm_pkg::RW_V1, st1_next.x);
        st1_next.a1    = bvdm_pkg::mul_x(bvdm_pkg::RB_S, st1_next.s);
        st1_next.a2c   = bvdm_pkg::RB_P + bvdm_pkg::mul_x(bvdm_pkg::RB_PS, st1_next.s);
        st1_next.a3    = bvdm_pkg::mul_x(bvdm_pkg::RB_TT, st1_next.x);
        st1_next.a4    = bvdm_pkg::mul_x(bvdm_pkg::RB_TS, st1_next.s);
        st1_next.a5c   = bvdm_pkg::RB_TP + bvdm_pkg::mul_x(bvdm_pkg::RB_TPS, st1_next.s);
    end

    // stage 2: second pressure step, sqrt steps 4-7
    always_comb
    begin
        st2_next.x  = st1_reg.x;
        st2_next.y  = st1_reg.y;
        st2_next.s  = st1_reg.s;
        st2_next.sq = bvdm_pkg::sqrt_steps(st1_reg.sq, 4);
        for (int i = 0; i < 5; i++)
        begin
            st2_next.wb[i] = bvdm_pkg::WV_COEF[i][1]
                           + bvdm_pkg::mul_y(st1_reg.wa[i], st1_reg.y);
        end
        st2_next.p2    = bvdm_pkg::mul_y(st1_reg.p1, st1_reg.y);
        st2_next.qs    = bvdm_pkg::VA_T1 + st1_reg.q1
                       + bvdm_pkg::mul_x(st1_reg.q2, st1_reg.x);
        st2_next.vbq   = bvdm_pkg::VB_C0 + bvdm_pkg::mul_y(st1_reg.vq, st1_reg.y);
        st2_next.m1820 = st1_reg.m1820;
        st2_next.dt2   = bvdm_pkg::RW_T1 + bvdm_pkg::mul_x(st1_reg.dt, st1_reg.x);
        st2_next.du2   = bvdm_pkg::RW_U1 + bvdm_pkg::mul_x(st1_reg.du, st1_reg.x);
        st2_next.dv2   = bvdm_pkg::mul_y(st1_reg.dv, st1_reg.y);
        st2_next.a1    = st1_reg.a1;
        st2_next.b1    = bvdm_pkg::mul_y(st1_reg.a2c, st1_reg.y);
        st2_next.bsum  = bvdm_pkg::RB_T + st1_reg.a3 + st1_reg.a4
                       + bvdm_pkg::mul_y(st1_reg.a5c, st1_reg.y);
    end

    // stage 3: velocity rows done, water density terms, sqrt steps 8-11
    always_comb
    begin
        st3_next.x  = st2_reg.x;
        st3_next.y  = st2_reg.y;
        st3_next.s  = st2_reg.s;
        st3_next.sq = bvdm_pkg::sqrt_steps(st2_reg.sq, 8);
        for (int i = 0; i < 5; i++)
        begin
            st3_next.rr[i] = bvdm_pkg::WV_COEF[i][0]
                           + bvdm_pkg::mul_y(st2_reg.wb[i], st2_reg.y);
        end
        st3_next.va    = bvdm_pkg::VA_C0 + st2_reg.p2
                       + bvdm_pkg::mul_x(st2_reg.qs, st2_reg.x);
        st3_next.vbq   = st2_reg.vbq;
        st3_next.m1820 = st2_reg.m1820;
        st3_next.tw    = bvdm_pkg::mul_x(st2_reg.dt2, st2_reg.x);
        st3_next.uw    = bvdm_pkg::RW_U0 + bvdm_pkg::mul_x(st2_reg.du2, st2_reg.x)
                       + st2_reg.dv2;
        st3_next.t2    = bvdm_pkg::RB_C0 + st2_reg.a1 + st2_reg.b1
                       + bvdm_pkg::mul_x(st2_reg.bsum, st2_reg.x);
    end

    // stage 4: first temperature step, water density, sqrt steps 12-15
    always_comb
    begin
        sq_last        = bvdm_pkg::sqrt_steps(st3_reg.sq, 12);
        st4_next.x     = st3_reg.x;
        st4_next.s     = st3_reg.s;
        st4_next.r     = sq_last.res[15:0];
        st4_next.h     = st3_reg.rr[3] + bvdm_pkg::mul_x(st3_reg.rr[4], st3_reg.x);
        st4_next.r0    = st3_reg.rr[0];
        st4_next.r1    = st3_reg.rr[1];
        st4_next.r2    = st3_reg.rr[2];
        st4_next.va    = st3_reg.va;
        st4_next.vbq   = st3_reg.vbq;
        st4_next.m1820 = st3_reg.m1820;
        st4_next.rw    = bvdm_pkg::RW_ONE + st3_reg.tw
                       + bvdm_pkg::mul_y(st3_reg.uw, st3_reg.y);
        st4_next.t2    = st3_reg.t2;
    end

    // stage 5: second temperature step, salinity^1.5 term, brine density
    always_comb
    begin
        st5_next.x   = st4_reg.x;
        st5_next.s   = st4_reg.s;
        st5_next.h   = st4_reg.r2 + bvdm_pkg::mul_x(st4_reg.h, st4_reg.x);
        st5_next.r0  = st4_reg.r0;
        st5_next.r1  = st4_reg.r1;
        st5_next.vin = st4_reg.va + bvdm_pkg::mul_x(st4_reg.vbq, st4_reg.r)
                     + st4_reg.m1820;
        st5_next.rw  = st4_reg.rw;
        st5_next.rb  = st4_reg.rw + bvdm_pkg::mul_x(st4_reg.t2, st4_reg.s);
    end

    // stage 6: third temperature step
    always_comb
    begin
        st6_next.x   = st5_reg.x;
        st6_next.s   = st5_reg.s;
        st6_next.h   = st5_reg.r1 + bvdm_pkg::mul_x(st5_reg.h, st5_reg.x);
        st6_next.r0  = st5_reg.r0;
        st6_next.vin = st5_reg.vin;
        st6_next.rw  = st5_reg.rw;
        st6_next.rb  = st5_reg.rb;
    end

    // stage 7: water velocity
    always_comb
    begin
        st7_next.s   = st6_reg.s;
        st7_next.vw  = st6_reg.r0 + bvdm_pkg::mul_x(st6_reg.h, st6_reg.x);
        st7_next.vin = st6_reg.vin;
        st7_next.rw  = st6_reg.rw;
        st7_next.rb  = st6_reg.rb;
    end

    // stage 8: brine velocity
    always_comb
    begin
        st8_next.vw = st7_reg.vw;
        st8_next.vb = st7_reg.vw + bvdm_pkg::mul_x(st7_reg.vin, st7_reg.s);
        st8_next.rw = st7_reg.rw;
        st8_next.rb = st7_reg.rb;
    end

    // stage 9: round and saturate the four outputs
    always_comb
    begin
        sat_vw = bvdm_pkg::sat_speed(st8_reg.vw);
        sat_vb = bvdm_pkg::sat_speed(st8_reg.vb);
        sat_rw = bvdm_pkg::sat_rho(st8_reg.rw);
        sat_rb = bvdm_pkg::sat_rho(st8_reg.rb);
        st9_next.o_vw = sat_vw.val;
        st9_next.o_vb = sat_vb.val;
        st9_next.o_rw = sat_rw.val;
        st9_next.o_rb = sat_rb.val;
        st9_next.clip = sat_vw.clip | sat_vb.clip | sat_rw.clip | sat_rb.clip;
        st9_next.acc  = '0;
    end

    // stage 10: v^2
    always_comb
    begin
        st10_next     = st9_reg;
        st10_next.acc = 58'(40'(st9_reg.o_vb) * 40'(st9_reg.o_vb));
    end

    // stage 11: rho * v^2
    always_comb
    begin
        st11_next     = st10_reg;
        st11_next.acc = 58'(st10_reg.acc[39:0]) * 58'(st10_reg.o_rb);
    end

    // stage 12: round, drop 2^31, multiply by the reciprocal of 125
    always_comb
    begin
        bulk_sum      = {1'b0, st11_reg.acc} + bvdm_pkg::BULK_HALF;
        st12_next     = st11_reg;
        st12_next.acc = 58'(57'(bulk_sum[58:31]) * 57'(bvdm_pkg::BULK_RECIP));
    end

    // stage 13: bulk modulus saturation, output register
    always_comb
    begin
        bulk_raw       = st12_reg.acc[56:35];
        st13_next.o_vw = st12_reg.o_vw;
        st13_next.o_vb = st12_reg.o_vb;
        st13_next.o_rw = st12_reg.o_rw;
        st13_next.o_rb = st12_reg.o_rb;
        if (bulk_raw > 22'(bvdm_pkg::BULK_MAX))
        begin
            st13_next.bulk = bvdm_pkg::BULK_MAX;
            st13_next.clip = 1'b1;
        end
        else
        begin
            st13_next.bulk = bulk_raw[16:0];
            st13_next.clip = st12_reg.clip;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en[1])  st1_reg  <= st1_next;
        if (en[2])  st2_reg  <= st2_next;
        if (en[3])  st3_reg  <= st3_next;
        if (en[4])  st4_reg  <= st4_next;
        if (en[5])  st5_reg  <= st5_next;
        if (en[6])  st6_reg  <= st6_next;
        if (en[7])  st7_reg  <= st7_next;
        if (en[8])  st8_reg  <= st8_next;
        if (en[9])  st9_reg  <= st9_next;
        if (en[10]) st10_reg <= st10_next;
        if (en[11]) st11_reg <= st11_next;
        if (en[12]) st12_reg <= st12_next;
        if (en[13]) st13_reg <= st13_next;
    end

    // ports
    assign s_axis_tready = en[1];
    assign m_axis_tvalid = vld_reg[13];
    assign m_axis_tdata  = {3'b000, st13_reg.bulk, st13_reg.o_rb, st13_reg.o_rw,
                            st13_reg.o_vb, st13_reg.o_vw};
    assign m_axis_tuser  = st13_reg.clip;

    // checks
    `ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_reg[1])
    `ASSERT_IMPLIES(a_empty_out_ready, !vld_reg[13], s_axis_tready)
    `ASSERT_NEXT(a_bulk_sat_flags, vld_reg[12] && en[13] && (bulk_raw > 22'(bvdm_pkg::BULK_MAX)), m_axis_tuser)

endmodule
